// File: rtl/palindrome_word_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palindrome word filter
// Clocked checks that are switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef PALINDROME_WORD_FILTER_ASSERT_SVH
`define PALINDROME_WORD_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// Palindrome word filter package
// Buffer sizes and the character classification helpers.
// ----------------------------------------------------------------------------
package pwf_pkg;

    localparam int MAX_WORD = 32;
    localparam int IDX_W    = $clog2(MAX_WORD);
    localparam int LEN_W    = $clog2(MAX_WORD + 1);

    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic [7:0]       char_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [LEN_W-1:0] len_t;

    function automatic logic is_word_char(input char_t c);
        return (c inside {[CH_UP_A:CH_LO_Z]}) || (c inside {[CH_DIG_0:CH_DIG_9]});
    endfunction

    function automatic char_t fold_case(input char_t c);
        if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            return c - CASE_OFS;
        end
        return c;
    endfunction

endpackage

// File: rtl/pwf_word_ram.sv
// ----------------------------------------------------------------------------
// Word buffer RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module pwf_word_ram
    import pwf_pkg::*;
(
    input  logic  aclk,
    input  logic  wr_en,
    input  idx_t  wr_addr,
    input  char_t wr_data,
    input  logic  rd_en_a,
    input  idx_t  rd_addr_a,
    output char_t rd_data_a,
    input  logic  rd_en_b,
    input  idx_t  rd_addr_b,
    output char_t rd_data_b
);

    char_t mem [MAX_WORD];
    char_t rd_data_a_reg;
    char_t rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en_a) begin
            rd_data_a_reg <= mem[rd_addr_a];
        end
        if (rd_en_b) begin
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: rtl/palindrome_word_filter.sv
// The word RAM read data is registered. At a word end of n characters the comparison reads
// the floor(n/2) character pairs in turn (S_CMP_RD) and checks each one (S_CMP_CHK),
// stopping at a mismatch; each byte of a palindrome is then read from the RAM (S_EMIT_RD)
// and loaded into the output register (S_EMIT_WR), which waits while the output holds a
// byte not yet taken. Input is taken only while no word is being checked or sent.
// Reset clears the control state and the output valid; the word RAM is not cleared.
// ----------------------------------------------------------------------------
// Palindrome word filter
// Gathers word characters into a RAM and streams out the palindromic words.
// ----------------------------------------------------------------------------
`include "palindrome_word_filter_assert.svh"

module palindrome_word_filter
    import pwf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast    // word_last
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CMP_RD  = 5'b00010,
        S_CMP_CHK = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT_WR = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    len_t   len_reg, len_next;
    logic   ovf_reg, ovf_next;
    idx_t   idx_reg, idx_next;
    logic   m_tvalid_reg, m_tvalid_next;
    char_t  m_tdata_reg, m_tdata_next;
    logic   m_tlast_reg, m_tlast_next;

    logic   in_fire;
    logic   in_word;
    logic   buf_full;
    logic   wr_en;
    logic   word_end;
    logic   ovf_new;
    len_t   len_new;
    len_t   hi_addr;
    char_t  rd_data_a;
    char_t  rd_data_b;
    logic   pair_last;
    logic   byte_last;
    logic   out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_word  = is_word_char(s_tdata);
    assign buf_full = (len_reg >= LEN_W'(MAX_WORD));
    assign wr_en    = in_fire && in_word && !buf_full;
    assign word_end = !in_word || s_tlast;
    assign ovf_new  = ovf_reg || (in_word && buf_full);
    assign len_new  = wr_en ? len_reg + LEN_W'(1) : len_reg;

    // Mirror index for the comparison: the partner of entry i is entry len-1-i.
    assign hi_addr   = len_reg - LEN_W'(1) - LEN_W'(idx_reg);
    assign pair_last = ((LEN_W'(idx_reg) + LEN_W'(1)) == (len_reg >> 1));
    assign byte_last = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    assign out_load  = (state_reg == S_EMIT_WR) && (!m_tvalid_reg || m_tready);

    pwf_word_ram u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (len_reg[IDX_W-1:0]),
        .wr_data   (s_tdata),
        .rd_en_a   ((state_reg == S_CMP_RD) || (state_reg == S_EMIT_RD)),
        .rd_addr_a (idx_reg),
        .rd_data_a (rd_data_a),
        .rd_en_b   (state_reg == S_CMP_RD),
        .rd_addr_b (hi_addr[IDX_W-1:0]),
        .rd_data_b (rd_data_b)
    );

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    len_next = len_new;
                    ovf_next = ovf_new;
                    if (word_end) begin
                        idx_next = '0;
                        ovf_next = 1'b0;
                        if (!ovf_new && (len_new >= LEN_W'(2))) begin
                            state_next = S_CMP_RD;
                        end else begin
                            len_next = '0;
                        end
                    end
                end
            end
            S_CMP_RD: begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (fold_case(rd_data_a) != fold_case(rd_data_b)) begin
                    state_next = S_IDLE;
                    len_next   = '0;
                end else if (pair_last) begin
                    state_next = S_EMIT_RD;
                    idx_next   = '0;
                end else begin
                    state_next = S_CMP_RD;
                    idx_next   = idx_reg + IDX_W'(1);
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd_data_a;
                    m_tlast_next  = byte_last;
                    if (byte_last) begin
                        state_next = S_IDLE;
                        len_next   = '0;
                    end else begin
                        state_next = S_EMIT_RD;
                        idx_next   = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
                len_next   = '0;
                ovf_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `PWF_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1,
        len_reg <= LEN_W'(MAX_WORD), "word length beyond buffer")
    `PWF_ASSERT_NOW(a_busy_len, aclk, aresetn, state_reg != S_IDLE,
        (len_reg >= LEN_W'(2)) && !ovf_reg, "checking a word that cannot be a palindrome")
    `PWF_ASSERT_NEXT(a_last_done, aclk, aresetn, out_load && byte_last,
        (state_reg == S_IDLE) && (len_reg == '0), "word not released after its last byte")

endmodule

// File: tb/sv/tb_palindrome_word_filter.sv
// ----------------------------------------------------------------------------
// Palindrome word filter testbench
// Streams text bytes into the filter and checks every emitted byte, and its
// end-of-palindrome flag, against a predictor of the palindromes in the text.
// The run starts with a short list of boundary bytes and then uses random
// text words, palindromes with mixed case, overlong words and noise.
// ----------------------------------------------------------------------------
module tb_palindrome_word_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import pwf_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_ITEMS = 435;
    localparam int MAX_GAP      = 11;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 40;
    localparam int FROM_MODEL   = -1;
    localparam int HOLD_AT      = NUM_DIRECTED + 120;
    localparam int DRAIN_AT_A   = NUM_DIRECTED;
    localparam int DRAIN_AT_B   = NUM_DIRECTED + 240;
    localparam int CALM_FROM    = NUM_DIRECTED + 300;
    localparam int CALM_TO      = CALM_FROM + 60;

    localparam char_t CH_UP_Z   = CH_LO_Z - CASE_OFS;
    localparam char_t CH_AT     = 8'h40;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_LBRACE = 8'h7B;
    localparam char_t CH_LBRACK = 8'h5B;
    localparam char_t CH_BTICK  = 8'h60;
    localparam char_t CH_SPACE  = 8'h20;

    typedef struct packed {
        char_t ch;
        logic  eot;
        int    typed_n;
    } text_byte_t;

    typedef struct packed {
        char_t ch;
        logic  last;
    } out_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;    // [7:0] char_in
    logic       s_tlast  = 1'b0;  // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [7:0] char_out
    logic       m_tlast;          // word_last

    // Predictor state: the text word gathered so far.
    char_t pal_buf [MAX_WORD];
    int    pal_len      = 0;
    logic  pal_overflow = 1'b0;

    out_byte_t  expected_bytes [$];
    text_byte_t text_bytes [$];

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned bytes_checked = 0;
    int unsigned pals_checked  = 0;
    int unsigned rx_wait       = 0;
    bit          calm_phase    = 1'b0;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;

    text_byte_t directed_rows [NUM_DIRECTED] = '{
        '{CH_UP_A,          1'b0, FROM_MODEL},
        '{CH_LO_Z,          1'b0, FROM_MODEL},
        '{8'h00,            1'b0, 0},           // "Az" differs once folded
        '{CH_LO_A,          1'b0, FROM_MODEL},
        '{CH_UP_A,          1'b0, FROM_MODEL},
        '{8'hFF,            1'b0, 2},           // "aA" matches without case
        '{CH_DIG_0,         1'b0, FROM_MODEL},
        '{CH_DIG_9,         1'b0, FROM_MODEL},
        '{CH_DIG_0,         1'b0, FROM_MODEL},
        '{CH_AT,            1'b0, 3},
        '{CH_LBRACK,        1'b0, FROM_MODEL},
        '{CH_BTICK,         1'b0, FROM_MODEL},
        '{CH_LBRACK,        1'b1, 3},           // end of text flushes after the byte
        '{8'h78,            1'b1, 0},           // single character
        '{CH_SLASH,         1'b0, 0},
        '{CH_COLON,         1'b0, 0},
        '{CH_LBRACE,        1'b0, 0},
        '{8'h62,            1'b0, FROM_MODEL},
        '{8'h42,            1'b1, 2},
        '{8'h80,            1'b1, 0},
        '{8'h6D,            1'b0, FROM_MODEL},
        '{CH_SPACE,         1'b0, 0},
        '{CH_UP_Z,          1'b0, FROM_MODEL},
        '{CH_LO_Z,          1'b0, FROM_MODEL},
        '{8'hFF,            1'b0, 2}
    };

    palindrome_word_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic is_text_char(input char_t c);
        return (c >= CH_UP_A && c <= CH_LO_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9);
    endfunction

    function automatic char_t upper_of(input char_t c);
        return (c >= CH_LO_A && c <= CH_LO_Z) ? (c ^ CASE_OFS) : c;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // Takes one accepted text byte and queues the palindrome that it completes.
    function automatic int predict_word_bytes(input char_t c, input logic eot);
        int        i;
        logic      is_pal;
        out_byte_t ob;
        if (is_text_char(c)) begin
            if (pal_len < MAX_WORD) begin
                pal_buf[pal_len] = c;
                pal_len++;
            end else begin
                pal_overflow = 1'b1;
            end
        end
        if (is_text_char(c) && !eot) begin
            return 0;
        end
        is_pal = !pal_overflow && pal_len >= 2;
        for (i = 0; i < pal_len / 2; i++) begin
            if (upper_of(pal_buf[i]) != upper_of(pal_buf[pal_len - 1 - i])) begin
                is_pal = 1'b0;
            end
        end
        i = is_pal ? pal_len : 0;
        if (is_pal) begin
            for (int k = 0; k < pal_len; k++) begin
                ob.ch   = pal_buf[k];
                ob.last = (k == pal_len - 1);
                expected_bytes.insert(expected_bytes.size(), ob);
            end
        end
        pal_len      = 0;
        pal_overflow = 1'b0;
        return i;
    endfunction

    function automatic int unsigned draw_gap();
        if (calm_phase || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic char_t rand_text_char();
        if ($urandom_range(0, 3) == 0) begin
            return char_t'($urandom_range(32'(CH_DIG_0), 32'(CH_DIG_9)));
        end
        return char_t'($urandom_range(32'(CH_UP_A), 32'(CH_LO_Z)));
    endfunction

    function automatic char_t rand_separator();
        char_t c;
        c = char_t'($urandom_range(0, 255));
        while (is_text_char(c)) begin
            c = char_t'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic char_t maybe_swap_case(input char_t c);
        if (upper_of(c) >= CH_UP_A && upper_of(c) <= CH_UP_Z && $urandom_range(0, 1) == 1) begin
            return c ^ CASE_OFS;
        end
        return c;
    endfunction

    // Queues a text word; a mirrored one is a palindrome with random case on
    // its second half. The word ends on a separator or on end of text.
    task automatic queue_word(input int len, input bit mirrored);
        char_t w [0:63];
        bit    at_end;
        at_end = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            if (mirrored && i >= (len + 1) / 2) begin
                w[i] = maybe_swap_case(w[len - 1 - i]);
            end else begin
                w[i] = rand_text_char();
            end
            text_bytes.insert(text_bytes.size(),
                              text_byte_t'{w[i], at_end && i == len - 1, FROM_MODEL});
        end
        if (!at_end) begin
            text_bytes.insert(text_bytes.size(),
                              text_byte_t'{rand_separator(), $urandom_range(0, 7) == 0,
                                           FROM_MODEL});
        end
    endtask

    task automatic build_text();
        int unsigned pick;
        foreach (directed_rows[i]) begin
            text_bytes.insert(text_bytes.size(), directed_rows[i]);
        end
        queue_word(MAX_WORD, 1'b1);
        queue_word(MAX_WORD + 1, 1'b1);
        while (text_bytes.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                queue_word(($urandom_range(0, 9) != 0) ? $urandom_range(2, 8)
                                                       : $urandom_range(9, MAX_WORD), 1'b1);
            end else if (pick < 15) begin
                queue_word($urandom_range(1, 10), 1'b0);
            end else if (pick == 15) begin
                queue_word($urandom_range(MAX_WORD + 1, MAX_WORD + 8),
                           1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    text_bytes.insert(text_bytes.size(),
                                      text_byte_t'{char_t'($urandom_range(0, 255)),
                                                   $urandom_range(0, 15) == 0, FROM_MODEL});
                end
            end
        end
    endtask

    // Output side: one gap drawn per byte, plus a single long hold-off that
    // lets the filter back up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h last %b", m_tdata, m_tlast));
                end else begin
                    if (m_tdata !== expected_bytes[0].ch) begin
                        report_mismatch($sformatf("char_out %h, expected %h",
                                                  m_tdata, expected_bytes[0].ch));
                    end
                    if (m_tlast !== expected_bytes[0].last) begin
                        report_mismatch($sformatf("word_last %b, expected %b on byte %h",
                                                  m_tlast, expected_bytes[0].last, m_tdata));
                    end
                    void'(expected_bytes.pop_front());
                end
                bytes_checked++;
                if (m_tlast) begin
                    pals_checked++;
                end
                rx_wait = draw_gap();
            end
            if (hold_req && !hold_done) begin
                rx_wait   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d bytes outstanding.",
                     cycle_count, expected_bytes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        text_byte_t  item;
        int unsigned gap;
        int          n;
        build_text();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int idx = 0; idx < text_bytes.size(); idx++) begin
            item       = text_bytes[idx];
            calm_phase = (idx >= CALM_FROM && idx < CALM_TO);
            if (idx == HOLD_AT) begin
                hold_req = 1'b1;
            end
            gap = draw_gap();
            if (idx == DRAIN_AT_A || idx == DRAIN_AT_B) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_bytes.size() != 0) @(posedge aclk);
            end else if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= item.ch;
            s_tlast  <= item.eot;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            n = predict_word_bytes(item.ch, item.eot);
            if (item.typed_n != FROM_MODEL && n != item.typed_n) begin
                report_mismatch($sformatf("row %0d: byte %h gives %0d bytes, table says %0d",
                                          idx, item.ch, n, item.typed_n));
            end
        end
        s_tvalid <= 1'b0;

        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d text bytes (%0d boundary cases, the rest random text words).",
                 text_bytes.size(), NUM_DIRECTED);
        $display("Checked %0d output bytes in %0d palindromes, %0d mismatches.",
                 bytes_checked, pals_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
